// ----- sv/tte_pkg.sv -----
package tte_pkg;

    // Field widths of the channels and registers.
    localparam int Z_W      = 13;
    localparam int SAMPLE_W = 10;
    localparam int THR_W    = 9;
    localparam int GAP_W    = 8;
    localparam int SCALE_W  = 16;
    localparam int BPM_W    = 10;
    localparam int GAPS_W   = 9;

    // Saturation limits of the result fields.
    localparam int BPM_MAX  = 999;
    localparam int GAPS_MAX = 511;

    // Register reset values.
    localparam logic [THR_W-1:0]   THR_RESET   = 9'd60;
    localparam logic [GAP_W-1:0]   GAP_RESET   = 8'd10;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd6000;

    // Configuration port.
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef enum logic [1:0] {
        REG_TAP_THRESHOLD = 2'd0,
        REG_MIN_GAP       = 2'd1,
        REG_RATE_SCALE    = 2'd2,
        REG_NONE          = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_SCAN,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// ----- sv/tte_in_if.sv -----
interface tte_in_if
    import tte_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [Z_W-1:0]      z_sample;
    logic                       end_of_batch;
    logic                       restart;

    modport source (output valid, z_sample, end_of_batch, restart, input ready);
    modport sink   (input valid, z_sample, end_of_batch, restart, output ready);
endinterface

// ----- sv/tte_out_if.sv -----
interface tte_out_if
    import tte_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [BPM_W-1:0]    bpm;
    logic [GAPS_W-1:0]   tap_gaps;

    modport source (output valid, bpm, tap_gaps, input ready);
    modport sink   (input valid, bpm, tap_gaps, output ready);
endinterface

// ----- sv/tte_ram.sv -----
module tte_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 300
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- sv/tap_tempo_bpm_estimator.sv -----
// Tap tempo estimator.
// The sample channel takes one z reading per request, with end_of_batch and
// restart flags. Each reading is scaled down by eight and written into a
// ring of the last WINDOW_DEPTH readings held in one synchronous RAM.
// A plain reading is stored as it is taken and the next may follow at once.
// A reading with restart, or the first after reset, first sweeps the whole
// RAM with that reading, one entry a cycle.
// A reading with end_of_batch starts a scan of the ring through the RAM read
// port, one entry a cycle, then a multiply step and a restoring divide of
// one quotient bit a cycle; the divide is skipped when no gap was counted.
// The result sits in an output register: a new reading is taken while it
// waits, and a finished scan holds in its last state until the register is
// free, so a stalled receiver only stalls the sample channel then.
// Reset clears the control state and restores the register defaults; the
// RAM contents are not cleared, since the first reading fills them.
// Registers over APB: tap_threshold at 0x0, min_gap at 0x4, rate_scale at 0x8.
module tap_tempo_bpm_estimator
    import tte_pkg::*;
#(
    parameter int WINDOW_DEPTH = 300
) (
    input  logic              clk,
    input  logic              rst_n,
    tte_in_if.sink            sample_ch,
    tte_out_if.source         result_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);
    localparam int AW  = $clog2(WINDOW_DEPTH);
    localparam int CW  = $clog2(WINDOW_DEPTH + 1);
    localparam int RCW = $clog2(WINDOW_DEPTH + 2);
    localparam int PW  = SCALE_W + CW;
    localparam int DCW = $clog2(PW);
    localparam logic [AW-1:0]  LAST_ADDR  = AW'(WINDOW_DEPTH - 1);
    localparam logic [RCW-1:0] READ_COUNT = RCW'(WINDOW_DEPTH + 1);

    // Registers.
    state_t               state_reg, state_next;
    logic [THR_W-1:0]     thr_reg;
    logic [GAP_W-1:0]     gap_reg;
    logic [SCALE_W-1:0]   scale_reg;
    logic                 primed_reg, primed_next;
    logic [AW-1:0]        wi_reg, wi_next;
    logic [SAMPLE_W-1:0]  smp_reg, smp_next;
    logic                 eob_reg, eob_next;
    logic [AW-1:0]        fill_reg, fill_next;
    logic [AW-1:0]        raddr_reg, raddr_next;
    logic [RCW-1:0]       rd_cnt_reg, rd_cnt_next;
    logic                 rvalid_reg, rvalid_next;
    logic [RCW-1:0]       ridx_reg, ridx_next;
    logic [SAMPLE_W-1:0]  prev_reg, prev_next;
    logic                 tvld_reg, tvld_next;
    logic                 tap_reg, tap_next;
    logic [AW-1:0]        ti_reg, ti_next;
    logic                 have_reg, have_next;
    logic [AW-1:0]        last_reg, last_next;
    logic [AW-1:0]        sum_reg, sum_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [PW-1:0]        quo_reg, quo_next;
    logic [AW-1:0]        rem_reg, rem_next;
    logic [DCW-1:0]       dcnt_reg, dcnt_next;
    logic                 ovalid_reg, ovalid_next;
    logic [BPM_W-1:0]     obpm_reg, obpm_next;
    logic [GAPS_W-1:0]    ogaps_reg, ogaps_next;

    // Combinational helpers.
    logic                  in_acc;
    logic                  out_free;
    logic [SAMPLE_W-1:0]   smp_in;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [SAMPLE_W-1:0]   ram_wdata;
    logic [SAMPLE_W-1:0]   ram_rdata;
    logic                  issue;
    logic signed [SAMPLE_W:0] diff;
    logic [SAMPLE_W:0]     mag;
    logic [AW-1:0]         gap_len;
    logic [AW:0]           trial;
    logic [AW:0]           trial_sub;
    logic [BPM_W-1:0]      bpm_sat;
    logic [CW+GAPS_W-1:0]  cnt_wide;
    logic [GAPS_W-1:0]     gaps_sat;
    reg_idx_t              reg_idx;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x);
        wrap_inc = (x == LAST_ADDR) ? '0 : x + AW'(1);
    endfunction

    // Sample ring.
    tte_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (raddr_reg),
        .rdata (ram_rdata)
    );

    // Configuration port.
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign pready  = 1'b1;

    always_comb
    begin
        unique case (reg_idx)
            REG_TAP_THRESHOLD: prdata = APB_DW'(thr_reg);
            REG_MIN_GAP:       prdata = APB_DW'(gap_reg);
            REG_RATE_SCALE:    prdata = APB_DW'(scale_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= THR_RESET;
            gap_reg   <= GAP_RESET;
            scale_reg <= SCALE_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_idx)
                REG_TAP_THRESHOLD: thr_reg   <= pwdata[THR_W-1:0];
                REG_MIN_GAP:       gap_reg   <= pwdata[GAP_W-1:0];
                REG_RATE_SCALE:    scale_reg <= pwdata[SCALE_W-1:0];
                default:           ;
            endcase
        end
    end

    // Handshakes and datapath pieces.
    assign sample_ch.ready    = (state_reg == ST_IDLE);
    assign in_acc             = sample_ch.valid && sample_ch.ready;
    assign out_free           = !ovalid_reg || result_ch.ready;
    assign smp_in             = sample_ch.z_sample[Z_W-1:3];
    assign result_ch.valid    = ovalid_reg;
    assign result_ch.bpm      = obpm_reg;
    assign result_ch.tap_gaps = ogaps_reg;

    assign issue     = (state_reg == ST_SCAN) && (rd_cnt_reg != READ_COUNT);
    assign diff      = $signed({prev_reg[SAMPLE_W-1], prev_reg})
                     - $signed({ram_rdata[SAMPLE_W-1], ram_rdata});
    assign mag       = diff[SAMPLE_W] ? {1'b0, SAMPLE_W'(-diff)}
                                      : {1'b0, diff[SAMPLE_W-1:0]};
    assign gap_len   = ti_reg - last_reg;
    assign trial     = {rem_reg, quo_reg[PW-1]};
    assign trial_sub = trial - {1'b0, sum_reg};
    assign bpm_sat   = (quo_reg > PW'(BPM_MAX)) ? BPM_W'(BPM_MAX) : quo_reg[BPM_W-1:0];
    assign cnt_wide  = {{GAPS_W{1'b0}}, cnt_reg};
    assign gaps_sat  = (cnt_wide > (CW+GAPS_W)'(GAPS_MAX))
                     ? GAPS_W'(GAPS_MAX) : cnt_wide[GAPS_W-1:0];

    // Ring write port: plain store on accept, or the fill sweep.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wi_reg;
        ram_wdata = smp_in;
        if (state_reg == ST_FILL)
        begin
            ram_we    = 1'b1;
            ram_waddr = fill_reg;
            ram_wdata = smp_reg;
        end
        else if (in_acc && primed_reg && !sample_ch.restart)
        begin
            ram_we = 1'b1;
        end
    end

    // Sequencer and next values.
    always_comb
    begin
        state_next  = state_reg;
        primed_next = primed_reg;
        wi_next     = wi_reg;
        smp_next    = smp_reg;
        eob_next    = eob_reg;
        fill_next   = fill_reg;
        raddr_next  = raddr_reg;
        rd_cnt_next = rd_cnt_reg;
        rvalid_next = issue;
        ridx_next   = rd_cnt_reg;
        prev_next   = prev_reg;
        tvld_next   = 1'b0;
        tap_next    = tap_reg;
        ti_next     = ti_reg;
        have_next   = have_reg;
        last_next   = last_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dcnt_next   = dcnt_reg;
        ovalid_next = ovalid_reg && !result_ch.ready;
        obpm_next   = obpm_reg;
        ogaps_next  = ogaps_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    smp_next = smp_in;
                    eob_next = sample_ch.end_of_batch;
                    if (!primed_reg || sample_ch.restart)
                    begin
                        fill_next  = '0;
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        wi_next    = wrap_inc(wi_reg);
                        raddr_next = wrap_inc(wi_reg);
                        if (sample_ch.end_of_batch)
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
                rd_cnt_next = '0;
                have_next   = 1'b0;
                sum_next    = '0;
                cnt_next    = '0;
            end

            ST_FILL:
            begin
                fill_next = wrap_inc(fill_reg);
                if (fill_reg == LAST_ADDR)
                begin
                    // Entry 0 already holds the reading, so the store is done.
                    primed_next = 1'b1;
                    wi_next     = AW'(1);
                    raddr_next  = AW'(1);
                    state_next  = eob_reg ? ST_SCAN : ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (issue)
                begin
                    rd_cnt_next = rd_cnt_reg + RCW'(1);
                    raddr_next  = wrap_inc(raddr_reg);
                end
                // Step detection on each pair of neighbours.
                if (rvalid_reg)
                begin
                    prev_next = ram_rdata;
                    if (ridx_reg != '0)
                    begin
                        tvld_next = 1'b1;
                        tap_next  = (mag > (SAMPLE_W+1)'(thr_reg));
                        ti_next   = AW'(ridx_reg - RCW'(1));
                    end
                end
                // Gap timing between taps.
                if (tvld_reg)
                begin
                    if (tap_reg)
                    begin
                        if (!have_reg)
                        begin
                            have_next = 1'b1;
                            last_next = ti_reg;
                        end
                        else if (gap_len > AW'(gap_reg))
                        begin
                            sum_next  = sum_reg + gap_len;
                            last_next = ti_reg;
                            cnt_next  = cnt_reg + CW'(1);
                        end
                    end
                    if (ti_reg == LAST_ADDR)
                    begin
                        state_next = ST_MUL;
                    end
                end
            end

            ST_MUL:
            begin
                quo_next  = PW'(scale_reg) * PW'(cnt_reg);
                rem_next  = '0;
                dcnt_next = DCW'(PW - 1);
                state_next = (cnt_reg == '0) ? ST_DONE : ST_DIV;
            end

            ST_DIV:
            begin
                // One restoring quotient bit per cycle.
                if (!trial_sub[AW])
                begin
                    rem_next = trial_sub[AW-1:0];
                    quo_next = {quo_reg[PW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[AW-1:0];
                    quo_next = {quo_reg[PW-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg - DCW'(1);
                if (dcnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    obpm_next   = (cnt_reg == '0) ? '0 : bpm_sat;
                    ogaps_next  = gaps_sat;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            primed_reg <= 1'b0;
            wi_reg     <= '0;
            fill_reg   <= '0;
            raddr_reg  <= '0;
            rd_cnt_reg <= '0;
            rvalid_reg <= 1'b0;
            ridx_reg   <= '0;
            tvld_reg   <= 1'b0;
            have_reg   <= 1'b0;
            dcnt_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            primed_reg <= primed_next;
            wi_reg     <= wi_next;
            fill_reg   <= fill_next;
            raddr_reg  <= raddr_next;
            rd_cnt_reg <= rd_cnt_next;
            rvalid_reg <= rvalid_next;
            ridx_reg   <= ridx_next;
            tvld_reg   <= tvld_next;
            have_reg   <= have_next;
            dcnt_reg   <= dcnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload state.
    always_ff @(posedge clk)
    begin
        smp_reg   <= smp_next;
        eob_reg   <= eob_next;
        prev_reg  <= prev_next;
        tap_reg   <= tap_next;
        ti_reg    <= ti_next;
        last_reg  <= last_next;
        sum_reg   <= sum_next;
        cnt_reg   <= cnt_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        obpm_reg  <= obpm_next;
        ogaps_reg <= ogaps_next;
    end
endmodule

// ----- sv/tte_checker.sv -----
module tte_checker
    import tte_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_valid,
    input logic              s_ready,
    input logic              s_eob,
    input logic              r_valid,
    input logic              r_ready,
    input logic [BPM_W-1:0]  r_bpm,
    input logic [GAPS_W-1:0] r_gaps
);
    logic [1:0] pend_reg;
    logic [1:0] pend_next;

    // Batch ends taken whose result has not yet been delivered.
    always_comb
    begin
        pend_next = pend_reg;
        if (s_valid && s_ready && s_eob)
        begin
            pend_next = pend_next + 2'd1;
        end
        if (r_valid && r_ready)
        begin
            pend_next = pend_next - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // A stalled result keeps its request and its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid && $stable(r_bpm) && $stable(r_gaps))
        else $error("result changed while stalled");

    // No result without a batch end taken before it.
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> pend_reg != 2'd0)
        else $error("result without a batch end");

    // At most one result waits while the sample channel is open.
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_ready |-> pend_reg <= 2'd1)
        else $error("sample channel open with a scan outstanding");

    // The tempo is saturated.
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> r_bpm <= BPM_W'(BPM_MAX))
        else $error("bpm above limit");

    // No counted gap means no tempo.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && r_gaps == '0 |-> r_bpm == '0)
        else $error("bpm without gaps");
endmodule

bind tap_tempo_bpm_estimator tte_checker u_tte_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (sample_ch.valid),
    .s_ready (sample_ch.ready),
    .s_eob   (sample_ch.end_of_batch),
    .r_valid (result_ch.valid),
    .r_ready (result_ch.ready),
    .r_bpm   (result_ch.bpm),
    .r_gaps  (result_ch.tap_gaps)
);
